>>> hw/rtl/rolling_hash_substring_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rolling hash substring detector
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_DETECTOR_TOP_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define RHSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhsd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RHSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhsd: next-cycle check failed");

`else

`define RHSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RHSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/rhsd_pkg.sv
// ----------------------------------------------------------------------------
// Rolling hash substring detector package
// Action codes, result bundle, hash type and small digit helpers.
// ----------------------------------------------------------------------------
package rhsd_pkg;

   localparam int HASH_W = 32;

   typedef logic [HASH_W-1:0] hash_type;

   // multiplicative inverse of 3 modulo 2^32: exact division by 3
   localparam hash_type INV3 = 32'hAAAA_AAAB;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_TEXT    = 2'd2
   } action_type;

   typedef struct packed {
      logic match_end;
      logic found;
      logic text_end;
      logic overflow_error;
   } result_type;

   // byte mod 3: 4 == 1 (mod 3), so add the base-4 digits and fold
   function automatic logic [1:0] mod3(input logic [7:0] b);
      logic [3:0] s;
      logic [2:0] t;
      begin
         s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
         t = 3'(s[3:2]) + 3'(s[1:0]);
         if (t >= 3'd6) begin
            mod3 = 2'(t - 3'd6);
         end else if (t >= 3'd3) begin
            mod3 = 2'(t - 3'd3);
         end else begin
            mod3 = t[1:0];
         end
      end
   endfunction

   // digit (0..2) times weight, by selection
   function automatic hash_type weigh(input logic [1:0] d, input hash_type w);
      case (d)
         2'd1:    weigh = w;
         2'd2:    weigh = w << 1;
         default: weigh = '0;
      endcase
   endfunction

endpackage

>>> hw/rtl/rhsd_core.sv
// ----------------------------------------------------------------------------
// Rolling hash substring detector datapath
// Pattern and window stores, the two hashes and the single-pass step logic.
// ----------------------------------------------------------------------------
module rhsd_core #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [1:0]           action,
   input  logic [7:0]           data_byte,
   input  logic                 last_of_text,
   output rhsd_pkg::result_type result
);
   import rhsd_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // stores (no reset: only written entries are ever compared)
   logic [7:0]       pat_ff [MAX_PATTERN];
   logic [7:0]       pat_in [MAX_PATTERN];
   logic [7:0]       win_ff [MAX_PATTERN];
   logic [7:0]       win_in [MAX_PATTERN];
   logic [7:0]       win_shift [MAX_PATTERN];

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] fill_ff, fill_in, fill_up;
   hash_type         phash_ff, phash_in;
   hash_type         whash_ff, whash_in;
   hash_type         topw_ff, topw_in, topw_up;
   logic             found_ff, found_in, found_now;

   logic [1:0]       digit, oldest;
   hash_type         roll_hash;
   logic             bytes_eq, is_match;

   // shared step terms
   always_comb begin
      digit   = mod3(data_byte);
      oldest  = (fill_ff >= len_ff) ? mod3(win_ff[0]) : 2'd0;
      // window hash is always a multiple of 3 after the oldest digit goes,
      // so multiplying by the inverse gives the exact quotient
      roll_hash = (whash_ff - hash_type'(oldest)) * INV3 + weigh(digit, topw_ff);
      topw_up   = (len_ff != '0) ? (topw_ff << 1) + topw_ff : topw_ff;
      fill_up   = (fill_ff < len_ff) ? fill_ff + LEN_W'(1) : fill_ff;

      // window shifted by one, newest byte at position m-1
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_shift[i] = win_ff[i];
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         if (LEN_W'(i + 1) < len_ff) begin
            win_shift[i] = win_ff[i + 1];
         end
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LEN_W'(i + 1) == len_ff) begin
            win_shift[i] = data_byte;
         end
      end

      // exact compare over the pattern length
      bytes_eq = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LEN_W'(i) < len_ff && win_shift[i] != pat_ff[i]) begin
            bytes_eq = 1'b0;
         end
      end

      is_match  = (fill_up == len_ff) && (roll_hash == phash_ff) && bytes_eq;
   end

   // next state and result per action
   always_comb begin
      len_in    = len_ff;
      fill_in   = fill_ff;
      phash_in  = phash_ff;
      whash_in  = whash_ff;
      topw_in   = topw_ff;
      found_in  = found_ff;
      found_now = 1'b0;
      pat_in    = pat_ff;
      win_in    = win_ff;
      result    = '0;
      unique case (action)
         ACT_CLEAR: begin
            len_in   = '0;
            phash_in = '0;
            topw_in  = hash_type'(1);
            fill_in  = '0;
            whash_in = '0;
            found_in = 1'b0;
         end
         ACT_PATTERN: begin
            if (len_ff >= LEN_W'(MAX_PATTERN)) begin
               result.overflow_error = 1'b1;
            end else begin
               for (int i = 0; i < MAX_PATTERN; i++) begin
                  if (LEN_W'(i) == len_ff) begin
                     pat_in[i] = data_byte;
                  end
               end
               topw_in  = topw_up;
               phash_in = phash_ff + weigh(digit, topw_up);
               len_in   = len_ff + LEN_W'(1);
               fill_in  = '0;
               whash_in = '0;
               found_in = 1'b0;
            end
         end
         ACT_TEXT: begin
            if (len_ff == '0) begin
               result.match_end = 1'b1;
            end else begin
               whash_in         = roll_hash;
               win_in           = win_shift;
               fill_in          = fill_up;
               result.match_end = is_match;
            end
            found_now    = found_ff | result.match_end;
            result.found = found_now;
            found_in     = found_now;
            // closing beat of a text: restart the window
            if (last_of_text) begin
               result.text_end = 1'b1;
               fill_in         = '0;
               whash_in        = '0;
               found_in        = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         fill_ff  <= '0;
         phash_ff <= '0;
         whash_ff <= '0;
         topw_ff  <= hash_type'(1);
         found_ff <= 1'b0;
      end else if (step_en) begin
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         phash_ff <= phash_in;
         whash_ff <= whash_in;
         topw_ff  <= topw_in;
         found_ff <= found_in;
      end
   end

   // byte stores
   always_ff @(posedge clock) begin
      if (step_en) begin
         pat_ff <= pat_in;
         win_ff <= win_in;
      end
   end

endmodule

>>> hw/rtl/rolling_hash_substring_detector_top.sv
// ----------------------------------------------------------------------------
// Rolling hash substring detector, top level
// Streaming exact substring search with a base-3 rolling hash prefilter.
// ----------------------------------------------------------------------------
// One beat in, one beat out: clear, pattern byte (up to MAX_PATTERN) or text
// byte. Each beat is processed combinationally and its result appears on
// the rsp_ port in the cycle after acceptance. A beat can be accepted every
// cycle while results are taken as they come; while a result waits for
// rsp_ready the input is held off, and it opens again in the cycle in which
// that result is taken. The cycle is set by the text step: rolling hash
// update (one 32-bit multiply by the inverse of 3) and a parallel byte
// compare of the window against the pattern.
`include "rolling_hash_substring_detector_top_macros.svh"

module rolling_hash_substring_detector_top #(
   parameter int MAX_PATTERN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_match_end,
   output logic       rsp_found,
   output logic       rsp_text_end,
   output logic       rsp_overflow_error
);
   import rhsd_pkg::*;

   logic       req_beat;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, step_res;

   // input side free whenever the result register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;

   rhsd_core #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_beat),
      .action       (req_action),
      .data_byte    (req_data_byte),
      .last_of_text (req_last_of_text),
      .result       (step_res)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_end      = rsp_ff.match_end;
   assign rsp_found          = rsp_ff.found;
   assign rsp_text_end       = rsp_ff.text_end;
   assign rsp_overflow_error = rsp_ff.overflow_error;

   // checks
   `RHSD_ASSERT_IMPLIES(a_match_sets_found, clock, reset,
                        rsp_valid_ff && rsp_ff.match_end, rsp_ff.found)
   `RHSD_ASSERT_IMPLIES(a_overflow_alone, clock, reset,
                        rsp_valid_ff && rsp_ff.overflow_error,
                        !rsp_ff.match_end && !rsp_ff.found && !rsp_ff.text_end)
   `RHSD_ASSERT_NEXT(a_beat_gives_result, clock, reset, req_beat, rsp_valid_ff)

endmodule
